[rtl/dtg_pkg.sv]
// Shared types and constants for the deinterlace timestamp generator.
// No dependencies; imported by every module of the block.
package dtg_pkg;

  localparam int DATE_W     = 64;
  localparam int FIELD_W    = 2;
  localparam int FIDX_W     = 2;
  localparam int RATE_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 72;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_STAMPS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DEN      = 3'd4;

  typedef struct packed {
    logic load;   // take the input request
    logic flush;  // with load: clear history instead of shifting
    logic prep;   // select base entry, scan history, form product
    logic setup;  // set up the duration divide and the frame counter
    logic next;   // advance to the next output frame
  } dtg_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic last;
  } dtg_status_t;

endpackage

[rtl/dtg_divider.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dtg_pkg for the dividend and divisor widths.
module dtg_divider import dtg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATE_W-1:0] dividend_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATE_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DATE_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RATE_W-1:0] rem_q;
  logic [DATE_W-1:0] quo_q;
  logic [RATE_W-1:0] dvs_q;
  logic [RATE_W+1:0] trial;
  logic              ge;

  assign trial = {1'b0, rem_q, quo_q[DATE_W-1]} - {2'b00, dvs_q};
  assign ge    = ~trial[RATE_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[RATE_W-1:0] : {rem_q[RATE_W-2:0], quo_q[DATE_W-1]};
      quo_q <= {quo_q[DATE_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/dtg_datapath.sv]
// Datapath: config registers, metadata history, duration maths and output frame state.
// Depends on dtg_pkg and dtg_divider.
module dtg_datapath import dtg_pkg::*; #(
  parameter int META_DEPTH       = 3,
  parameter int HOLD_DEPTH       = 3,
  parameter int MAX_OUT_FRAMES   = 3,
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [DATE_W-1:0]     in_date_i,
  input  logic [FIELD_W-1:0]    in_fields_i,
  input  logic                  in_tff_i,
  input  dtg_cmd_t              cmd_i,
  output dtg_status_t           status_o,
  output logic [FIDX_W-1:0]     frame_index_o,
  output logic [DATE_W-1:0]     out_date_o,
  output logic                  bottom_field_o,
  output logic                  last_frame_o
);

  localparam int HIDX_W = $clog2(META_DEPTH);
  localparam int HELD_W = $clog2(HOLD_DEPTH + 1);
  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int SUM_W  = $clog2(META_DEPTH * 3 + 1);
  localparam int PROD_W = RATE_W + TPS_W;
  localparam logic [TPS_W-1:0]  TPS      = TPS_W'(TICKS_PER_SECOND);
  localparam logic [FIDX_W-1:0] MAX_FRMS = FIDX_W'(MAX_OUT_FRAMES);

  // config
  logic              dbl_q, cust_q;
  logic [1:0]        fdel_q;
  logic [RATE_W-1:0] rnum_q, rden_q;

  // history
  logic [DATE_W-1:0]  hist_date_q   [META_DEPTH];
  logic [FIELD_W-1:0] hist_fields_q [META_DEPTH];
  logic               hist_tff_q    [META_DEPTH];
  logic [HELD_W-1:0]  held_q, held_nxt;
  logic               cact_q;

  // captured request
  logic [DATE_W-1:0]  in_date_q;
  logic [FIELD_W-1:0] in_fields_q;
  logic               in_tff_q;
  logic               cur_cust_q;

  // prep results
  logic [DATE_W-1:0] base_q, diff_q, prod_q;
  logic              use_tff_q, found_q, need_div_q;
  logic [FIDX_W-1:0] last_idx_q;
  logic [SUM_W-1:0]  total_q;

  // frame state
  logic [DATE_W-1:0] dur_q, acc_q;
  logic [FIDX_W-1:0] frame_q;
  logic              zero_q, neg_q;

  logic [HIDX_W-1:0]  sel;
  logic               found;
  logic [DATE_W-1:0]  first_date;
  logic [SUM_W-1:0]   total;
  logic [FIELD_W-1:0] use_fields;
  logic [FIDX_W-1:0]  cnt;
  logic [PROD_W-1:0]  mult;
  logic [DATE_W-1:0]  mag, dividend, quotient;
  logic [RATE_W-1:0]  divisor;
  logic               skip, div_start, div_done;

  assign held_nxt = (held_q < HELD_W'(HOLD_DEPTH)) ? held_q + 1'b1 : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_q  <= 1'b0;
      cust_q <= 1'b0;
      fdel_q <= '0;
      rnum_q <= '0;
      rden_q <= RATE_W'(1);
      for (int i = 0; i < META_DEPTH; i++) begin
        hist_date_q[i]   <= '0;
        hist_fields_q[i] <= FIELD_W'(2);
        hist_tff_q[i]    <= 1'b1;
      end
      held_q <= '0;
      cact_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_DOUBLE_RATE:   dbl_q  <= cfg_data_i[0];
          REG_CUSTOM_STAMPS: cust_q <= cfg_data_i[0];
          REG_FRAME_DELAY:   fdel_q <= cfg_data_i[1:0];
          REG_RATE_NUM:      rnum_q <= cfg_data_i[RATE_W-1:0];
          REG_RATE_DEN:      rden_q <= cfg_data_i[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        if (cmd_i.flush) begin
          for (int i = 0; i < META_DEPTH; i++) begin
            hist_date_q[i]   <= '0;
            hist_fields_q[i] <= FIELD_W'(2);
            hist_tff_q[i]    <= 1'b1;
          end
          held_q <= '0;
          cact_q <= 1'b0;
        end else begin
          for (int i = 0; i < META_DEPTH - 1; i++) begin
            hist_date_q[i]   <= hist_date_q[i+1];
            hist_fields_q[i] <= hist_fields_q[i+1];
            hist_tff_q[i]    <= hist_tff_q[i+1];
          end
          hist_date_q[META_DEPTH-1]   <= in_date_i;
          hist_fields_q[META_DEPTH-1] <= in_fields_i;
          hist_tff_q[META_DEPTH-1]    <= in_tff_i;
          held_q <= held_nxt;
          if (cust_q && held_nxt >= HELD_W'(HOLD_DEPTH - 1)) cact_q <= 1'b1;
        end
      end
    end
  end

  // delay saturates at the oldest entry
  always_comb begin
    if (int'(fdel_q) >= META_DEPTH - 1) sel = '0;
    else sel = HIDX_W'(META_DEPTH - 1 - int'(fdel_q));
  end

  // oldest valid date among all but the newest entry, and fields summed from there on
  always_comb begin
    found      = 1'b0;
    first_date = '0;
    total      = '0;
    for (int j = 0; j < META_DEPTH - 1; j++) begin
      if (!found && hist_date_q[j] != '0) begin
        found      = 1'b1;
        first_date = hist_date_q[j];
      end
      if (found) total = total + SUM_W'(hist_fields_q[j]);
    end
  end

  assign use_fields = cur_cust_q ? in_fields_q : hist_fields_q[sel];

  always_comb begin
    if (!dbl_q) cnt = FIDX_W'(1);
    else if (use_fields > MAX_FRMS) cnt = MAX_FRMS;
    else if (use_fields == '0) cnt = FIDX_W'(1);
    else cnt = use_fields;
  end

  assign mult = rden_q * TPS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_date_q   <= in_date_i;
      in_fields_q <= in_fields_i;
      in_tff_q    <= in_tff_i;
      cur_cust_q  <= cact_q;
    end
    if (cmd_i.prep) begin
      base_q     <= cur_cust_q ? in_date_q : hist_date_q[sel];
      use_tff_q  <= cur_cust_q ? in_tff_q : hist_tff_q[sel];
      last_idx_q <= cnt - 1'b1;
      found_q    <= found;
      total_q    <= total;
      diff_q     <= in_date_q - first_date;
      prod_q     <= {{(DATE_W - PROD_W){1'b0}}, mult};
      need_div_q <= dbl_q & ~cur_cust_q;
    end
    if (cmd_i.setup) begin
      dur_q   <= '0;
      acc_q   <= base_q;
      frame_q <= '0;
      zero_q  <= (base_q == '0);
      neg_q   <= found_q & diff_q[DATE_W-1];
    end
    if (div_done) dur_q <= neg_q ? (~quotient + 1'b1) : quotient;
    if (cmd_i.next) begin
      acc_q   <= acc_q + dur_q;
      frame_q <= frame_q + 1'b1;
    end
  end

  // divide magnitude by field sum, or fall back to the frame rate
  assign mag      = diff_q[DATE_W-1] ? (~diff_q + 1'b1) : diff_q;
  assign dividend = found_q ? mag : prod_q;
  assign divisor  = found_q ? RATE_W'(total_q) : rnum_q;
  assign skip     = found_q ? (total_q == '0) : (rnum_q == '0);

  assign div_start = cmd_i.setup & status_o.need_div;

  dtg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign status_o.need_div = need_div_q & ~skip;
  assign status_o.div_done = div_done;
  assign status_o.last     = (frame_q == last_idx_q);

  assign frame_index_o  = frame_q;
  assign out_date_o     = zero_q ? '0 : acc_q;
  assign bottom_field_o = dbl_q & (frame_q[0] ? use_tff_q : ~use_tff_q);
  assign last_frame_o   = (frame_q == last_idx_q);

endmodule

[rtl/dtg_ctrl.sv]
// Controller: sequences load, prep, divide and frame output for each request.
// Depends on dtg_pkg for the command and status structs.
module dtg_ctrl import dtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_action_i,
  input  logic        m_ready_i,
  input  dtg_status_t status_i,
  output dtg_cmd_t    cmd_o,
  output logic        s_ready_o,
  output logic        m_valid_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.flush = s_action_i;
          if (!s_action_i) state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = status_i.need_div ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          if (status_i.last) state_d = ST_IDLE;
          else cmd_o.next = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule

[rtl/deinterlace_timestamp_generator_unit.sv]
// Top level of the deinterlace timestamp generator.
// Depends on dtg_pkg, dtg_ctrl and dtg_datapath.
//
// Usage:
//  - Input stream: one request per picture. tuser is the action (0 picture,
//    1 flush). A flush clears the metadata history and gives no output.
//  - Output stream: one frame per picture, or one per field (up to
//    MAX_OUT_FRAMES) in double rate mode; tlast marks the last frame of a run.
//  - Config port: write-only, always ready; write only while the block is idle.
//  - Sequence: a picture passes the prep and setup states before its first frame is
//    offered, and the divide state too when a field duration is needed (double rate,
//    not in custom mode, non-zero divisor): the bit-serial 64-bit divider takes one
//    quotient bit per cycle.
//  - Throughput: one request at a time; tready rises again the cycle after
//    the last frame of a run is taken. A flush is taken in the idle state.
//  - Stall: frames wait in the output register while tready is low, with
//    tdata and tlast held.
//  - Reset: history dates invalid, field counts two, top field first, config
//    back to defaults (rate base 1); no frame pending.
module deinterlace_timestamp_generator_unit import dtg_pkg::*; #(
  parameter int META_DEPTH       = 3,
  parameter int HOLD_DEPTH       = 3,
  parameter int MAX_OUT_FRAMES   = 3,
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // pic_date[63:0], field_count[65:64],
                                               // top_first[66], zero pad
  input  logic [0:0]            s_axis_tuser,  // action[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // frame_index[1:0], out_date[65:2],
                                               // bottom_field[66], zero pad
  output logic                  m_axis_tlast,  // last_frame
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PAD_W = M_TDATA_W - FIDX_W - DATE_W - 1;

  dtg_cmd_t          cmd;
  dtg_status_t       status;
  logic [FIDX_W-1:0] frame_index;
  logic [DATE_W-1:0] out_date;
  logic              bottom_field;

  assign cfg_ready_o = 1'b1;

  dtg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_action_i (s_axis_tuser[0]),
    .m_ready_i  (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .s_ready_o  (s_axis_tready),
    .m_valid_o  (m_axis_tvalid)
  );

  dtg_datapath #(
    .META_DEPTH       (META_DEPTH),
    .HOLD_DEPTH       (HOLD_DEPTH),
    .MAX_OUT_FRAMES   (MAX_OUT_FRAMES),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_date_i      (s_axis_tdata[DATE_W-1:0]),
    .in_fields_i    (s_axis_tdata[DATE_W+FIELD_W-1:DATE_W]),
    .in_tff_i       (s_axis_tdata[DATE_W+FIELD_W]),
    .cmd_i          (cmd),
    .status_o       (status),
    .frame_index_o  (frame_index),
    .out_date_o     (out_date),
    .bottom_field_o (bottom_field),
    .last_frame_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, bottom_field, out_date, frame_index};

endmodule

[test/testbench.sv]
// Self-checking bench for deinterlace_timestamp_generator_unit: streams picture and flush
// requests under random stalls, predicts every output frame and compares it field by field.
// Depends on dtg_pkg and the RTL of the block.
module testbench;
  import dtg_pkg::*;

  localparam int META_DEPTH       = 3;
  localparam int HOLD_DEPTH       = 3;
  localparam int MAX_OUT_FRAMES   = 3;
  localparam int TICKS_PER_SECOND = 1000000;

  localparam logic ACT_PICTURE = 1'b0;
  localparam logic ACT_FLUSH   = 1'b1;

  // bit positions inside tdata
  localparam int FC_LSB    = DATE_W;
  localparam int TFF_BIT   = DATE_W + FIELD_W;
  localparam int ODATE_LSB = FIDX_W;
  localparam int OBOT_BIT  = FIDX_W + DATE_W;

  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_CYCLES  = 100;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 500;
  localparam int HOLD_AFTER    = 150;
  localparam int TAIL_REQS     = 30;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQS    = 48;

  typedef struct {
    logic                  is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  action;
    logic [DATE_W-1:0]     date;
    logic [FIELD_W-1:0]    fields;
    logic                  tff;
  } pending_t;

  typedef struct packed {
    logic [FIDX_W-1:0] index;
    logic [DATE_W-1:0] date;
    logic              bottom;
    logic              last;
  } frame_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // predictor copy of history and registers
  logic [DATE_W-1:0]  past_date   [META_DEPTH];
  logic [FIELD_W-1:0] past_fields [META_DEPTH];
  logic               past_tff    [META_DEPTH];
  int unsigned        pics_held;
  logic               stamps_live;
  logic               dbl_rate;
  logic               stamps_en;
  logic [1:0]         delay_sel;
  logic [RATE_W-1:0]  rate_n;
  logic [RATE_W-1:0]  rate_d;

  frame_t   frames_due   [$];
  pending_t pending_reqs [$];
  frame_t   want;
  pending_t head;

  int   failures     = 0;
  int   reqs_done    = 0;
  int   writes_done  = 0;
  int   frames_seen  = 0;
  int   quiet_cycles = 0;
  int   reqs_mark    = 0;
  int   writes_mark  = 0;
  int   send_gap     = 0;
  int   take_gap     = 0;
  int   hold_left    = 0;
  logic held_off     = 1'b0;
  logic offer_req    = 1'b0;
  logic offer_write  = 1'b0;
  logic fired;
  logic may_idle     = 1'b0;
  logic [DATE_W-1:0] walk_date = '0;

  deinterlace_timestamp_generator_unit #(
    .META_DEPTH      (META_DEPTH),
    .HOLD_DEPTH      (HOLD_DEPTH),
    .MAX_OUT_FRAMES  (MAX_OUT_FRAMES),
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic void wipe_history();
    int i;
    for (i = 0; i < META_DEPTH; i++) begin
      past_date[i]   = '0;
      past_fields[i] = FIELD_W'(2);
      past_tff[i]    = 1'b1;
    end
    pics_held   = 0;
    stamps_live = 1'b0;
  endfunction

  // signed span from the oldest valid entry over the fields since, else the rate
  function automatic logic [DATE_W-1:0] field_step(input logic [DATE_W-1:0] now);
    int                first;
    int                j;
    logic [DATE_W-1:0] diff;
    logic [DATE_W-1:0] mag;
    logic [DATE_W-1:0] quot;
    logic [DATE_W-1:0] total;
    first = META_DEPTH - 1;
    for (j = META_DEPTH - 2; j >= 0; j--)
      if (past_date[j] != '0) first = j;
    if (first < META_DEPTH - 1) begin
      total = '0;
      for (j = first; j < META_DEPTH - 1; j++) total += DATE_W'(past_fields[j]);
      if (total == '0) return '0;
      diff = now - past_date[first];
      mag  = diff[DATE_W-1] ? -diff : diff;
      quot = mag / total;
      return diff[DATE_W-1] ? -quot : quot;
    end
    if (rate_n != '0) return (DATE_W'(rate_d) * DATE_W'(TICKS_PER_SECOND)) / DATE_W'(rate_n);
    return '0;
  endfunction

  function automatic void predict_picture(input logic [DATE_W-1:0] date,
                                          input logic [FIELD_W-1:0] fields, input logic tff);
    logic               custom;
    int                 pos;
    int                 count;
    int                 i;
    logic               use_tff;
    logic [FIELD_W-1:0] use_fields;
    logic [DATE_W-1:0]  base;
    logic [DATE_W-1:0]  step;
    logic [DATE_W-1:0]  mult;
    frame_t             f;
    custom = stamps_live;
    for (i = 1; i < META_DEPTH; i++) begin
      past_date[i-1]   = past_date[i];
      past_fields[i-1] = past_fields[i];
      past_tff[i-1]    = past_tff[i];
    end
    past_date[META_DEPTH-1]   = date;
    past_fields[META_DEPTH-1] = fields;
    past_tff[META_DEPTH-1]    = tff;
    if (pics_held < HOLD_DEPTH) pics_held++;
    pos = (META_DEPTH - 1) - ((delay_sel > META_DEPTH - 1) ? META_DEPTH - 1 : int'(delay_sel));
    if (custom) begin
      use_tff    = tff;
      use_fields = fields;
      base       = date;
    end else begin
      use_tff    = past_tff[pos];
      use_fields = past_fields[pos];
      base       = past_date[pos];
    end
    count = 1;
    step  = '0;
    if (dbl_rate) begin
      count = (use_fields > MAX_OUT_FRAMES) ? MAX_OUT_FRAMES : int'(use_fields);
      if (count < 1) count = 1;
      if (!custom) step = field_step(date);
    end
    // custom mode switches on for the next picture, not this one
    if (stamps_en && pics_held >= HOLD_DEPTH - 1) stamps_live = 1'b1;
    for (i = 0; i < count; i++) begin
      mult     = DATE_W'(i);
      f.index  = FIDX_W'(i);
      f.date   = (custom || base == '0) ? base : base + mult * step;
      f.bottom = dbl_rate ? ((i % 2 == 1) ? use_tff : ~use_tff) : 1'b0;
      f.last   = (i == count - 1);
      frames_due.push_back(f);
    end
  endfunction

  task automatic add_pic(input logic [DATE_W-1:0] date, input logic [FIELD_W-1:0] fields,
                         input logic tff);
    pending_t r;
    r.is_write = 1'b0;
    r.reg_idx  = '0;
    r.reg_val  = '0;
    r.action   = ACT_PICTURE;
    r.date     = date;
    r.fields   = fields;
    r.tff      = tff;
    pending_reqs.push_back(r);
  endtask

  task automatic add_flush();
    pending_t r;
    r.is_write = 1'b0;
    r.reg_idx  = '0;
    r.reg_val  = '0;
    r.action   = ACT_FLUSH;
    r.date     = {$urandom, $urandom};
    r.fields   = FIELD_W'($urandom_range(0, 3));
    r.tff      = 1'($urandom_range(0, 1));
    pending_reqs.push_back(r);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    pending_t r;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_val  = val;
    r.action   = ACT_PICTURE;
    r.date     = '0;
    r.fields   = '0;
    r.tff      = 1'b0;
    pending_reqs.push_back(r);
  endtask

  // mostly a steady walk of dates, now and then invalid, backwards or anywhere
  function automatic logic [DATE_W-1:0] next_date();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       walk_date = {$urandom, $urandom};
      2:       walk_date = walk_date - $urandom_range(1, 40000);
      default: walk_date = walk_date + $urandom_range(1000, 40000);
    endcase
    return walk_date;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_fields();
    case ($urandom_range(0, 9))
      0:       return FIELD_W'(0);
      1:       return FIELD_W'(1);
      2:       return FIELD_W'(3);
      default: return FIELD_W'(2);
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate(input logic allow_zero);
    case ($urandom_range(0, 4))
      0:       return allow_zero ? '0 : RATE_W'(1);
      1:       return '1;
      2:       return $urandom | 32'h1;
      default: return RATE_W'($urandom_range(1, 120));
    endcase
  endfunction

  // sampling, prediction and checking at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      fired = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_DOUBLE_RATE:   dbl_rate  = cfg_data_i[0];
          REG_CUSTOM_STAMPS: stamps_en = cfg_data_i[0];
          REG_FRAME_DELAY:   delay_sel = cfg_data_i[1:0];
          REG_RATE_NUM:      rate_n    = cfg_data_i;
          REG_RATE_DEN:      rate_d    = cfg_data_i;
          default: ;
        endcase
        writes_done++;
        fired = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == ACT_FLUSH) wipe_history();
        else predict_picture(s_axis_tdata[DATE_W-1:0], s_axis_tdata[FC_LSB +: FIELD_W],
                             s_axis_tdata[TFF_BIT]);
        reqs_done++;
        fired = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (frames_due.size() == 0) begin
          $error("unexpected frame: frame_index %0d out_date %h",
                 m_axis_tdata[FIDX_W-1:0], m_axis_tdata[ODATE_LSB +: DATE_W]);
          failures++;
        end else begin
          want = frames_due.pop_front();
          if (m_axis_tdata[FIDX_W-1:0] !== want.index) begin
            $error("frame_index: expected %0d, got %0d", want.index, m_axis_tdata[FIDX_W-1:0]);
            failures++;
          end
          if (m_axis_tdata[ODATE_LSB +: DATE_W] !== want.date) begin
            $error("out_date: expected %h, got %h", want.date,
                   m_axis_tdata[ODATE_LSB +: DATE_W]);
            failures++;
          end
          if (m_axis_tdata[OBOT_BIT] !== want.bottom) begin
            $error("bottom_field: expected %0d, got %0d", want.bottom, m_axis_tdata[OBOT_BIT]);
            failures++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_frame: expected %0d, got %0d", want.last, m_axis_tlast);
            failures++;
          end
        end
        frames_seen++;
        fired = 1'b1;
      end
      // idle bursts only outside the calm stretches and the tail
      may_idle = pending_reqs.size() > TAIL_REQS && (reqs_done / 40) % 3 != 1;
      if (fired) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // request and register-write driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (reqs_done != reqs_mark || writes_done != writes_mark) begin
        reqs_mark   = reqs_done;
        writes_mark = writes_done;
        offer_req   = 1'b0;
        offer_write = 1'b0;
        if (may_idle && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 19);
      end
      if (!offer_req && !offer_write) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          if (!pending_reqs[0].is_write) begin
            head = pending_reqs.pop_front();
            s_axis_tdata <= {{(S_TDATA_W - TFF_BIT - 1){1'b0}}, head.tff, head.fields, head.date};
            s_axis_tuser <= head.action;
            offer_req = 1'b1;
          end else if (frames_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
            // a flush may still be in flight, hence the settle count
            head = pending_reqs.pop_front();
            cfg_index_i <= head.reg_idx;
            cfg_data_i  <= head.reg_val;
            offer_write = 1'b1;
          end
        end
      end
      s_axis_tvalid <= offer_req;
      cfg_valid_i   <= offer_write;
    end
  end

  // frame receiver: random stalls plus one long hold-off while requests queue up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!held_off && frames_seen >= HOLD_AFTER && s_axis_tvalid && !s_axis_tready) begin
        hold_left = LONG_HOLD;
        held_off  = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else if (may_idle && $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int p;
    int k;
    wipe_history();
    dbl_rate  = 1'b0;
    stamps_en = 1'b0;
    delay_sel = '0;
    rate_n    = '0;
    rate_d    = RATE_W'(1);

    // single rate from reset: date and field extremes
    add_pic(64'd1000, 2'd2, 1'b1);
    add_pic('0, 2'd1, 1'b0);
    add_pic(64'h7FFF_FFFF_FFFF_FFFF, 2'd3, 1'b0);
    add_pic(64'h8000_0000_0000_0000, 2'd0, 1'b1);
    add_pic('1, 2'd2, 1'b0);
    // double rate, oldest entry, unknown rate; zero fields still give one frame
    add_write(REG_DOUBLE_RATE, 32'd1);
    add_write(REG_FRAME_DELAY, 32'd2);
    add_pic(64'd5000, 2'd0, 1'b1);
    add_pic(64'd6000, 2'd1, 1'b0);
    add_pic(64'd7000, 2'd3, 1'b1);
    add_flush();
    add_pic(64'd9000, 2'd3, 1'b1);
    // empty history falls back to the frame rate
    add_write(REG_FRAME_DELAY, 32'd0);
    add_write(REG_RATE_NUM, 32'd25);
    add_write(REG_RATE_DEN, 32'd1);
    add_flush();
    add_pic(64'd100000, 2'd3, 1'b0);
    add_pic(64'd140000, 2'd2, 1'b1);
    // delay beyond the history saturates; wrapping and negative spans
    add_write(REG_FRAME_DELAY, 32'd3);
    add_pic(64'h8000_0000_0000_0000, 2'd3, 1'b1);
    add_pic(64'h7FFF_FFFF_FFFF_FFFF, 2'd3, 1'b0);
    add_pic(64'd10, 2'd2, 1'b1);
    // rate extremes, then custom stamps with an invalid input date
    add_write(REG_FRAME_DELAY, 32'd1);
    add_write(REG_RATE_NUM, '1);
    add_write(REG_RATE_DEN, '1);
    add_write(REG_CUSTOM_STAMPS, 32'd1);
    add_flush();
    add_pic(64'd20000, 2'd3, 1'b0);
    add_pic(64'd21000, 2'd1, 1'b1);
    add_pic(64'd22000, 2'd2, 1'b0);
    add_pic('0, 2'd3, 1'b1);
    add_flush();
    add_pic(64'd24000, 2'd2, 1'b1);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      add_write(REG_DOUBLE_RATE, CFG_DATA_W'(p % 3 != 2));
      add_write(REG_CUSTOM_STAMPS, CFG_DATA_W'(p % 2));
      add_write(REG_FRAME_DELAY, CFG_DATA_W'($urandom_range(0, 3)));
      add_write(REG_RATE_NUM, (p == 0) ? '0 : pick_rate(1'b1));
      add_write(REG_RATE_DEN, (p == RANDOM_PHASES - 1) ? '1 : pick_rate(1'b0));
      walk_date = {$urandom, $urandom} >> $urandom_range(0, 40);
      for (k = 0; k < PHASE_REQS; k++) begin
        if ($urandom_range(0, 19) == 0) add_flush();
        else add_pic(next_date(), pick_fields(), 1'($urandom_range(0, 1)));
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || offer_req || offer_write) @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
rtl/dtg_pkg.sv
rtl/dtg_divider.sv
rtl/dtg_datapath.sv
rtl/dtg_ctrl.sv
rtl/deinterlace_timestamp_generator_unit.sv
test/testbench.sv
